// ===== rtl/tsvm_pkg.sv =====
// Shared types and codes for the typed stack machine executor.
package tsvm_pkg;

    localparam logic [4:0] OP_PUSH        = 5'd0;
    localparam logic [4:0] OP_PUSH_GLOBAL = 5'd1;
    localparam logic [4:0] OP_PUSH_LOCAL  = 5'd2;
    localparam logic [4:0] OP_POP_GLOBAL  = 5'd3;
    localparam logic [4:0] OP_POP_LOCAL   = 5'd4;
    localparam logic [4:0] OP_POPN        = 5'd5;
    localparam logic [4:0] OP_ADD         = 5'd6;
    localparam logic [4:0] OP_SUB         = 5'd7;
    localparam logic [4:0] OP_MUL         = 5'd8;
    localparam logic [4:0] OP_DIV         = 5'd9;
    localparam logic [4:0] OP_LESS        = 5'd10;
    localparam logic [4:0] OP_CALL        = 5'd11;
    localparam logic [4:0] OP_NEW_FRAME   = 5'd12;
    localparam logic [4:0] OP_BRANCH      = 5'd13;
    localparam logic [4:0] OP_CONDBRANCH  = 5'd14;
    localparam logic [4:0] OP_RETURN      = 5'd15;
    localparam logic [4:0] OP_LABEL       = 5'd16;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TYPE    = 3'd1;
    localparam logic [2:0] ST_NONFUNC = 3'd2;
    localparam logic [2:0] ST_HALTED  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN = 3'd4;
    localparam logic [2:0] ST_STACK   = 3'd5;
    localparam logic [2:0] ST_DIVZERO = 3'd6;
    localparam logic [2:0] ST_HOST    = 3'd7;

    localparam logic [2:0] TAG_INT  = 3'd1;
    localparam logic [2:0] TAG_FUNC = 3'd2;
    localparam logic [2:0] TAG_HOST = 3'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_PUSHW,
        S_STORE,
        S_ARA,
        S_ARB,
        S_ITER,
        S_ARW,
        S_CALL,
        S_CB,
        S_RET,
        S_RET2,
        S_TOP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [4:0]         cmd;
        logic [10:0]        slot_or_count;
        logic [31:0]        target_true;
        logic [31:0]        target_false;
        logic [31:0]        return_addr;
        logic signed [63:0] push_value;
        logic [2:0]         push_tag;
    } instr_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               redirect;
        logic [31:0]        next_pc;
        logic signed [63:0] top_value;
        logic [2:0]         top_tag;
        logic [10:0]        stack_depth;
    } result_t;

endpackage

// ===== rtl/typed_stack_vm_executor_unit.sv =====
// Top level of the typed stack machine executor: sequencer, stacks and shared ALU.
//
// The block executes one decoded stack machine instruction per input item and
// returns one result item with the status, an optional pc redirect, the top of
// the value stack and the stack depth. Every stack access goes through the single
// read port of the value stack memory, and each operand or top-of-stack read is
// a separate registered access. Multiply and divide run on one shared 64-bit
// shift-and-add unit at one bit per cycle. The block accepts no new item until
// the current one has moved into the output register; a finished result may
// wait there while the next item is already being worked on. Faulting
// instructions change no state, and after a return from the outermost frame
// every item reports the halted status.
module typed_stack_vm_executor_unit #(
    parameter int STACK_DEPTH = 1024,
    parameter int CALL_DEPTH  = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 instr_valid,
    output logic                 instr_stall,
    input  tsvm_pkg::instr_t     instr,
    output logic                 result_valid,
    input  logic                 result_stall,
    output tsvm_pkg::result_t    result
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int SW = $clog2(STACK_DEPTH + 1);
    localparam int CA = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;
    localparam int CW = $clog2(CALL_DEPTH + 1);
    localparam int IW = ((SW > 11) ? SW : 11) + 1;

    // Value stack and call stack memories.
    logic [63:0] val_mem [STACK_DEPTH];
    logic [2:0]  tag_mem [STACK_DEPTH];
    logic [31:0] ret_mem [CALL_DEPTH];
    logic [SW-1:0] frm_mem [CALL_DEPTH];

    tsvm_pkg::state_t state_reg, state_next;
    tsvm_pkg::instr_t item_reg;
    logic [SW-1:0] sp_reg, sp_next;
    logic [SW-1:0] fb_reg, fb_next;
    logic [CW-1:0] cd_reg, cd_next;
    logic          halted_reg, halted_next;
    logic [63:0]   a_reg, a_next;
    logic [63:0]   x_reg, x_next;
    logic [63:0]   y_reg, y_next;
    logic [63:0]   acc_reg, acc_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic [2:0]    status_reg, status_next;
    logic          redir_reg, redir_next;
    logic [31:0]   npc_reg, npc_next;
    tsvm_pkg::result_t out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    // Memory ports.
    logic [AW-1:0] rd_addr;
    logic [63:0]   rd_val;
    logic [2:0]    rd_tag;
    logic          st_we;
    logic [AW-1:0] st_waddr;
    logic [63:0]   st_wval;
    logic [2:0]    st_wtag;
    logic          cs_we;
    logic [CA-1:0] cs_waddr;
    logic [CA-1:0] cs_raddr;
    logic [31:0]   ret_q;
    logic [SW-1:0] frm_q;

    // Decode helpers.
    logic [IW-1:0] sc_w, sp_w, idx_w;
    logic          idx_ok, sp_full, is_div;
    logic [SW-1:0] sp_m1, sp_m2;
    logic [64:0]   div_trial, alu_sum;
    logic [63:0]   alu_b;
    logic [63:0]   cmp_a, cmp_b;
    logic [63:0]   neg_y;

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            val_mem[st_waddr] <= st_wval;
            tag_mem[st_waddr] <= st_wtag;
        end
        rd_val <= val_mem[rd_addr];
        rd_tag <= tag_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cs_we)
        begin
            ret_mem[cs_waddr] <= item_reg.return_addr;
            frm_mem[cs_waddr] <= fb_reg;
        end
        ret_q <= ret_mem[cs_raddr];
        frm_q <= frm_mem[cs_raddr];
    end

    assign sc_w    = IW'(item_reg.slot_or_count);
    assign sp_w    = IW'(sp_reg);
    assign idx_w   = (item_reg.cmd == tsvm_pkg::OP_PUSH_GLOBAL ||
                      item_reg.cmd == tsvm_pkg::OP_POP_GLOBAL) ? sc_w : IW'(fb_reg) + sc_w;
    assign idx_ok  = idx_w < IW'(STACK_DEPTH);
    assign sp_full = sp_w >= IW'(STACK_DEPTH);
    assign sp_m1   = sp_reg - SW'(1);
    assign sp_m2   = sp_reg - SW'(2);
    assign is_div  = item_reg.cmd == tsvm_pkg::OP_DIV;
    assign neg_y   = 64'd0 - y_reg;

    // Shared adder: accumulate for multiply, trial subtract for divide.
    assign div_trial = {acc_reg, y_reg[63]};
    assign alu_b     = y_reg[0] ? x_reg : 64'd0;
    assign alu_sum   = is_div ? (div_trial - {1'b0, x_reg}) : ({1'b0, acc_reg} + {1'b0, alu_b});

    // Signed compare as an offset unsigned compare, b < a.
    assign cmp_a = a_reg ^ 64'h8000_0000_0000_0000;
    assign cmp_b = rd_val ^ 64'h8000_0000_0000_0000;

    assign instr_stall  = state_reg != tsvm_pkg::S_IDLE;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        sp_next        = sp_reg;
        fb_next        = fb_reg;
        cd_next        = cd_reg;
        halted_next    = halted_reg;
        a_next         = a_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        neg_next       = neg_reg;
        status_next    = status_reg;
        redir_next     = redir_reg;
        npc_next       = npc_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && result_stall;
        rd_addr        = sp_m1[AW-1:0];
        st_we          = 1'b0;
        st_waddr       = sp_reg[AW-1:0];
        st_wval        = rd_val;
        st_wtag        = rd_tag;
        cs_we          = 1'b0;
        cs_waddr       = cd_reg[CA-1:0];
        cs_raddr       = cd_reg[CA-1:0] - CA'(1);

        case (state_reg)
            tsvm_pkg::S_IDLE:
            begin
                if (instr_valid)
                begin
                    status_next = tsvm_pkg::ST_OK;
                    redir_next  = 1'b0;
                    npc_next    = 32'd0;
                    state_next  = tsvm_pkg::S_DEC;
                end
            end

            tsvm_pkg::S_DEC:
            begin
                state_next = tsvm_pkg::S_TOP;
                if (halted_reg)
                begin
                    status_next = tsvm_pkg::ST_HALTED;
                end
                else
                begin
                    case (item_reg.cmd)
                        tsvm_pkg::OP_PUSH:
                        begin
                            if (sp_full)
                                status_next = tsvm_pkg::ST_STACK;
                            else
                            begin
                                st_we   = 1'b1;
                                st_wval = item_reg.push_value;
                                st_wtag = item_reg.push_tag;
                                sp_next = sp_reg + SW'(1);
                            end
                        end
                        tsvm_pkg::OP_PUSH_GLOBAL, tsvm_pkg::OP_PUSH_LOCAL:
                        begin
                            if (sp_full || !idx_ok)
                                status_next = tsvm_pkg::ST_STACK;
                            else
                            begin
                                rd_addr    = idx_w[AW-1:0];
                                state_next = tsvm_pkg::S_PUSHW;
                            end
                        end
                        tsvm_pkg::OP_POP_GLOBAL, tsvm_pkg::OP_POP_LOCAL:
                        begin
                            if (sp_reg == '0 || !idx_ok)
                                status_next = tsvm_pkg::ST_STACK;
                            else
                                state_next = tsvm_pkg::S_STORE;
                        end
                        tsvm_pkg::OP_POPN:
                        begin
                            if (sc_w > sp_w)
                                status_next = tsvm_pkg::ST_STACK;
                            else
                                sp_next = sp_reg - SW'(item_reg.slot_or_count);
                        end
                        tsvm_pkg::OP_ADD, tsvm_pkg::OP_SUB, tsvm_pkg::OP_MUL,
                        tsvm_pkg::OP_DIV, tsvm_pkg::OP_LESS:
                        begin
                            if (sp_w < IW'(2))
                                status_next = tsvm_pkg::ST_STACK;
                            else
                                state_next = tsvm_pkg::S_ARA;
                        end
                        tsvm_pkg::OP_CALL:
                        begin
                            if (sp_reg == '0)
                                status_next = tsvm_pkg::ST_STACK;
                            else
                                state_next = tsvm_pkg::S_CALL;
                        end
                        tsvm_pkg::OP_NEW_FRAME, tsvm_pkg::OP_LABEL:
                        begin
                            status_next = tsvm_pkg::ST_OK;
                        end
                        tsvm_pkg::OP_BRANCH:
                        begin
                            redir_next = 1'b1;
                            npc_next   = item_reg.target_true;
                        end
                        tsvm_pkg::OP_CONDBRANCH:
                        begin
                            if (sp_reg == '0)
                                status_next = tsvm_pkg::ST_STACK;
                            else
                                state_next = tsvm_pkg::S_CB;
                        end
                        tsvm_pkg::OP_RETURN:
                        begin
                            // New depth is sp + 1 - frame size, kept in 1..STACK_DEPTH.
                            if (sp_reg == '0 || sc_w > sp_w ||
                                (sp_w - sc_w) >= IW'(STACK_DEPTH))
                                status_next = tsvm_pkg::ST_STACK;
                            else
                                state_next = tsvm_pkg::S_RET;
                        end
                        default:
                        begin
                            status_next = tsvm_pkg::ST_UNKNOWN;
                        end
                    endcase
                end
            end

            tsvm_pkg::S_PUSHW:
            begin
                st_we      = 1'b1;
                sp_next    = sp_reg + SW'(1);
                state_next = tsvm_pkg::S_TOP;
            end

            tsvm_pkg::S_STORE:
            begin
                st_we      = 1'b1;
                st_waddr   = idx_w[AW-1:0];
                sp_next    = sp_m1;
                state_next = tsvm_pkg::S_TOP;
            end

            tsvm_pkg::S_ARA:
            begin
                // Top operand has arrived; fetch the one beneath it.
                a_next     = rd_val;
                neg_next   = rd_tag == tsvm_pkg::TAG_INT;
                rd_addr    = sp_m2[AW-1:0];
                state_next = tsvm_pkg::S_ARB;
            end

            tsvm_pkg::S_ARB:
            begin
                state_next = tsvm_pkg::S_TOP;
                if (!neg_reg || rd_tag != tsvm_pkg::TAG_INT)
                    status_next = tsvm_pkg::ST_TYPE;
                else
                begin
                    case (item_reg.cmd)
                        tsvm_pkg::OP_ADD, tsvm_pkg::OP_SUB, tsvm_pkg::OP_LESS:
                        begin
                            st_we    = 1'b1;
                            st_waddr = sp_m2[AW-1:0];
                            st_wtag  = tsvm_pkg::TAG_INT;
                            if (item_reg.cmd == tsvm_pkg::OP_ADD)
                                st_wval = rd_val + a_reg;
                            else if (item_reg.cmd == tsvm_pkg::OP_SUB)
                                st_wval = rd_val - a_reg;
                            else
                                st_wval = {63'd0, cmp_b < cmp_a};
                            sp_next = sp_m1;
                        end
                        tsvm_pkg::OP_MUL:
                        begin
                            x_next     = a_reg;
                            y_next     = rd_val;
                            acc_next   = 64'd0;
                            cnt_next   = '0;
                            state_next = tsvm_pkg::S_ITER;
                        end
                        default:
                        begin
                            if (a_reg == 64'd0)
                                status_next = tsvm_pkg::ST_DIVZERO;
                            else
                            begin
                                // Divide magnitudes, fix the sign at the end.
                                x_next     = a_reg[63] ? 64'd0 - a_reg : a_reg;
                                y_next     = rd_val[63] ? 64'd0 - rd_val : rd_val;
                                neg_next   = a_reg[63] ^ rd_val[63];
                                acc_next   = 64'd0;
                                cnt_next   = '0;
                                state_next = tsvm_pkg::S_ITER;
                            end
                        end
                    endcase
                end
            end

            tsvm_pkg::S_ITER:
            begin
                if (is_div)
                begin
                    if (alu_sum[64])
                        acc_next = div_trial[63:0];
                    else
                        acc_next = alu_sum[63:0];
                    y_next = {y_reg[62:0], ~alu_sum[64]};
                end
                else
                begin
                    acc_next = alu_sum[63:0];
                    x_next   = {x_reg[62:0], 1'b0};
                    y_next   = {1'b0, y_reg[63:1]};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = tsvm_pkg::S_ARW;
            end

            tsvm_pkg::S_ARW:
            begin
                st_we    = 1'b1;
                st_waddr = sp_m2[AW-1:0];
                st_wtag  = tsvm_pkg::TAG_INT;
                if (is_div)
                    st_wval = neg_reg ? neg_y : y_reg;
                else
                    st_wval = acc_reg;
                sp_next    = sp_m1;
                state_next = tsvm_pkg::S_TOP;
            end

            tsvm_pkg::S_CALL:
            begin
                state_next = tsvm_pkg::S_TOP;
                if (rd_tag == tsvm_pkg::TAG_FUNC)
                begin
                    if (sp_w < IW'(2) || cd_reg >= CW'(CALL_DEPTH))
                        status_next = tsvm_pkg::ST_STACK;
                    else
                    begin
                        cs_we      = 1'b1;
                        npc_next   = rd_val[31:0];
                        redir_next = 1'b1;
                        cd_next    = cd_reg + CW'(1);
                        sp_next    = sp_m1;
                        fb_next    = sp_m2;
                    end
                end
                else if (rd_tag == tsvm_pkg::TAG_HOST)
                    status_next = (sp_w < IW'(2)) ? tsvm_pkg::ST_STACK : tsvm_pkg::ST_HOST;
                else
                    status_next = tsvm_pkg::ST_NONFUNC;
            end

            tsvm_pkg::S_CB:
            begin
                sp_next    = sp_m1;
                redir_next = 1'b1;
                npc_next   = (rd_val == 64'd0) ? item_reg.target_false : item_reg.target_true;
                state_next = tsvm_pkg::S_TOP;
            end

            tsvm_pkg::S_RET:
            begin
                // Move the return value down to the caller's top slot.
                st_we    = 1'b1;
                st_waddr = AW'(sp_w - sc_w);
                sp_next  = SW'(sp_w - sc_w) + SW'(1);
                if (cd_reg == '0)
                begin
                    fb_next     = '0;
                    halted_next = 1'b1;
                    status_next = tsvm_pkg::ST_HALTED;
                    state_next  = tsvm_pkg::S_TOP;
                end
                else
                begin
                    cd_next    = cd_reg - CW'(1);
                    state_next = tsvm_pkg::S_RET2;
                end
            end

            tsvm_pkg::S_RET2:
            begin
                fb_next    = frm_q;
                npc_next   = ret_q;
                redir_next = 1'b1;
                state_next = tsvm_pkg::S_TOP;
            end

            tsvm_pkg::S_TOP:
            begin
                state_next = tsvm_pkg::S_OUT;
            end

            tsvm_pkg::S_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next.status      = status_reg;
                    out_next.redirect    = redir_reg;
                    out_next.next_pc     = npc_reg;
                    out_next.top_value   = (sp_reg == '0) ? 64'd0 : rd_val;
                    out_next.top_tag     = (sp_reg == '0) ? 3'd0 : rd_tag;
                    out_next.stack_depth = 11'(sp_reg);
                    out_valid_next       = 1'b1;
                    state_next           = tsvm_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tsvm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsvm_pkg::S_IDLE;
            sp_reg        <= '0;
            fb_reg        <= '0;
            cd_reg        <= '0;
            halted_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sp_reg        <= sp_next;
            fb_reg        <= fb_next;
            cd_reg        <= cd_next;
            halted_reg    <= halted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == tsvm_pkg::S_IDLE && instr_valid)
            item_reg <= instr;
        a_reg      <= a_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        acc_reg    <= acc_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        status_reg <= status_next;
        redir_reg  <= redir_next;
        npc_reg    <= npc_next;
        out_reg    <= out_next;
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the typed stack machine executor.
`timescale 1ns / 1ps

module tb_top;
    import tsvm_pkg::*;

    localparam int STACK_DEPTH = 1024;
    localparam int CALL_DEPTH  = 64;
    // Cycles without any handshake before the run is declared hung; a multiply or
    // divide and a receiver stall burst both lengthen the wait.
    localparam int HANG_LIMIT  = 3000;
    // Random steps; together with the stack fill and the call nesting below
    // this comes to about 1500 items.
    localparam int RANDOM_ITEMS = 300;

    logic    clk;
    logic    rst_n;
    logic    instr_valid;
    logic    instr_stall;
    instr_t  instr;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    typed_stack_vm_executor_unit #(
        .STACK_DEPTH(STACK_DEPTH),
        .CALL_DEPTH (CALL_DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr_valid (instr_valid),
        .instr_stall (instr_stall),
        .instr       (instr),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Shadow machine state. It always reflects every item handed to the
    // block so far, since items are predicted when they are first driven.
    logic [63:0] stack_val [STACK_DEPTH];
    logic [2:0]  stack_tag [STACK_DEPTH];
    bit          slot_written [STACK_DEPTH];
    logic [31:0] ret_pc [CALL_DEPTH];
    int          ret_fp [CALL_DEPTH];
    int          sp;
    int          fp;
    int          cdepth;
    bit          is_halted;

    result_t pending_results[$];
    int      mismatches;
    bit      quiet;
    int      idle_cycles;

    // Signed divide on magnitudes; the most negative value over -1 wraps.
    function automatic logic [63:0] div_trunc(logic [63:0] num, logic [63:0] den);
        logic [63:0] mn;
        logic [63:0] md;
        logic [63:0] q;
        mn = num[63] ? -num : num;
        md = den[63] ? -den : den;
        q = mn / md;
        return (num[63] != den[63]) ? -q : q;
    endfunction

    // Executes one instruction on the shadow state and returns its result.
    function automatic result_t exec_instr(instr_t x);
        result_t     r;
        int          idx;
        int          nt;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] v;
        logic [2:0]  t;
        r = '0;
        r.status = ST_OK;
        if (is_halted) begin
            r.status = ST_HALTED;
        end else begin
            case (x.cmd)
                OP_PUSH: begin
                    if (sp >= STACK_DEPTH) r.status = ST_STACK;
                    else begin
                        stack_val[sp] = x.push_value;
                        stack_tag[sp] = x.push_tag;
                        slot_written[sp] = 1'b1;
                        sp++;
                    end
                end
                OP_PUSH_GLOBAL, OP_PUSH_LOCAL: begin
                    idx = (x.cmd == OP_PUSH_GLOBAL) ? int'(x.slot_or_count)
                                                    : fp + int'(x.slot_or_count);
                    if (sp >= STACK_DEPTH || idx >= STACK_DEPTH) r.status = ST_STACK;
                    else begin
                        stack_val[sp] = stack_val[idx];
                        stack_tag[sp] = stack_tag[idx];
                        slot_written[sp] = 1'b1;
                        sp++;
                    end
                end
                OP_POP_GLOBAL, OP_POP_LOCAL: begin
                    idx = (x.cmd == OP_POP_GLOBAL) ? int'(x.slot_or_count)
                                                   : fp + int'(x.slot_or_count);
                    if (sp == 0 || idx >= STACK_DEPTH) r.status = ST_STACK;
                    else begin
                        sp--;
                        stack_val[idx] = stack_val[sp];
                        stack_tag[idx] = stack_tag[sp];
                        slot_written[idx] = 1'b1;
                    end
                end
                OP_POPN: begin
                    if (int'(x.slot_or_count) > sp) r.status = ST_STACK;
                    else sp -= int'(x.slot_or_count);
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_LESS: begin
                    if (sp < 2) r.status = ST_STACK;
                    else if (stack_tag[sp-1] != TAG_INT || stack_tag[sp-2] != TAG_INT)
                        r.status = ST_TYPE;
                    else begin
                        a = stack_val[sp-1];
                        b = stack_val[sp-2];
                        if (x.cmd == OP_DIV && a == 64'd0) r.status = ST_DIVZERO;
                        else begin
                            case (x.cmd)
                                OP_ADD:  v = a + b;
                                OP_SUB:  v = b - a;
                                OP_MUL:  v = a * b;
                                OP_DIV:  v = div_trunc(b, a);
                                default: v = ($signed(b) < $signed(a)) ? 64'd1 : 64'd0;
                            endcase
                            sp -= 2;
                            stack_val[sp] = v;
                            stack_tag[sp] = TAG_INT;
                            sp++;
                        end
                    end
                end
                OP_CALL: begin
                    if (sp == 0) r.status = ST_STACK;
                    else if (stack_tag[sp-1] == TAG_FUNC) begin
                        if (sp < 2 || cdepth >= CALL_DEPTH) r.status = ST_STACK;
                        else begin
                            r.next_pc = stack_val[sp-1][31:0];
                            r.redirect = 1'b1;
                            ret_pc[cdepth] = x.return_addr;
                            ret_fp[cdepth] = fp;
                            cdepth++;
                            sp--;
                            fp = sp - 1;
                        end
                    end else if (stack_tag[sp-1] == TAG_HOST)
                        r.status = (sp < 2) ? ST_STACK : ST_HOST;
                    else
                        r.status = ST_NONFUNC;
                end
                OP_NEW_FRAME, OP_LABEL: ;
                OP_BRANCH: begin
                    r.redirect = 1'b1;
                    r.next_pc = x.target_true;
                end
                OP_CONDBRANCH: begin
                    if (sp == 0) r.status = ST_STACK;
                    else begin
                        sp--;
                        r.redirect = 1'b1;
                        r.next_pc = (stack_val[sp] == 64'd0) ? x.target_false
                                                             : x.target_true;
                    end
                end
                OP_RETURN: begin
                    nt = sp + 1 - int'(x.slot_or_count);
                    if (sp == 0 || nt < 1 || nt > STACK_DEPTH) r.status = ST_STACK;
                    else begin
                        v = stack_val[sp-1];
                        t = stack_tag[sp-1];
                        sp = nt - 1;
                        stack_val[sp] = v;
                        stack_tag[sp] = t;
                        slot_written[sp] = 1'b1;
                        sp++;
                        if (cdepth == 0) begin
                            fp = 0;
                            is_halted = 1'b1;
                            r.status = ST_HALTED;
                        end else begin
                            cdepth--;
                            fp = ret_fp[cdepth];
                            r.next_pc = ret_pc[cdepth];
                            r.redirect = 1'b1;
                        end
                    end
                end
                default: r.status = ST_UNKNOWN;
            endcase
        end
        if (sp > 0) begin
            r.top_value = stack_val[sp-1];
            r.top_tag = stack_tag[sp-1];
        end
        r.stack_depth = sp[10:0];
        return r;
    endfunction

    function automatic instr_t make_instr(logic [4:0] op, int sc, logic [63:0] val,
                                          logic [2:0] tag);
        instr_t x;
        x.cmd = op;
        x.slot_or_count = sc[10:0];
        x.target_true = $urandom;
        x.target_false = $urandom;
        x.return_addr = $urandom;
        x.push_value = val;
        x.push_tag = tag;
        return x;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Keeps random items inside the contract: no read of a slot that was
    // never written, and no accidental halt from the outermost frame.
    function automatic instr_t make_legal(instr_t x);
        int idx;
        if (x.cmd == OP_PUSH_GLOBAL || x.cmd == OP_PUSH_LOCAL) begin
            idx = (x.cmd == OP_PUSH_GLOBAL) ? int'(x.slot_or_count)
                                            : fp + int'(x.slot_or_count);
            if (idx < STACK_DEPTH && !slot_written[idx]) x.cmd = OP_LABEL;
        end
        if (x.cmd == OP_RETURN && cdepth == 0 && !is_halted && sp > 0
            && int'(x.slot_or_count) <= sp && sp + 1 - int'(x.slot_or_count) <= STACK_DEPTH)
            x.slot_or_count = 11'(sp + 1 + $urandom_range(0, 7));
        return x;
    endfunction

    // Hands one item to the block. The expectation is queued at once; the
    // result cannot appear before the item is accepted.
    task automatic send(instr_t x, bit fixed, result_t fixed_res);
        result_t predicted;
        predicted = exec_instr(x);
        pending_results.push_back(fixed ? fixed_res : predicted);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            instr_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        instr <= x;
        instr_valid <= 1'b1;
        do @(posedge clk); while (instr_stall !== 1'b0);
        @(negedge clk);
    endtask

    task automatic send_op(instr_t x);
        send(x, 1'b0, '0);
    endtask

    task automatic send_legal(instr_t x);
        send(make_legal(x), 1'b0, '0);
    endtask

    // One random instruction or a short well-formed sequence.
    task automatic random_step();
        int r;
        int k;
        instr_t x;
        r = $urandom_range(0, 99);
        x = make_instr(5'($urandom), $urandom_range(0, 2047), rand64(),
                       3'($urandom));
        if (sp > 60) begin
            send_op(make_instr(OP_POPN, sp / 2, rand64(), 3'($urandom)));
        end else if (r < 20) begin
            send_op(make_instr(OP_PUSH, 0,
                ($urandom_range(0, 1) != 0) ? rand64() : 64'($signed($urandom_range(0, 40)) - 20),
                TAG_INT));
        end else if (r < 25) begin
            x.cmd = OP_PUSH;
            send_op(x);
        end else if (r < 37) begin
            if (sp < 2 || $urandom_range(0, 2) != 0) begin
                send_op(make_instr(OP_PUSH, 0, rand64(), TAG_INT));
                send_op(make_instr(OP_PUSH, 0,
                    ($urandom_range(0, 3) == 0) ? 64'($signed($urandom_range(0, 6)) - 3)
                                                : rand64(),
                    ($urandom_range(0, 9) == 0) ? 3'($urandom) : TAG_INT));
            end
            x.cmd = 5'(int'(OP_ADD) + $urandom_range(0, 4));
            send_op(x);
        end else if (r < 44) begin
            x.cmd = ($urandom_range(0, 1) != 0) ? OP_PUSH_GLOBAL : OP_PUSH_LOCAL;
            x.slot_or_count = ($urandom_range(0, 7) == 0) ? 11'($urandom)
                                                           : 11'($urandom_range(0, 40));
            send_legal(x);
        end else if (r < 51) begin
            x.cmd = ($urandom_range(0, 1) != 0) ? OP_POP_GLOBAL : OP_POP_LOCAL;
            x.slot_or_count = ($urandom_range(0, 7) == 0) ? 11'($urandom)
                                                           : 11'($urandom_range(0, 40));
            send_op(x);
        end else if (r < 56) begin
            x.cmd = OP_POPN;
            x.slot_or_count = ($urandom_range(0, 5) == 0) ? 11'($urandom)
                                                           : 11'($urandom_range(0, sp));
            send_op(x);
        end else if (r < 66) begin
            if (sp == 0) send_op(make_instr(OP_PUSH, 0, rand64(), TAG_INT));
            k = $urandom_range(0, 9);
            send_op(make_instr(OP_PUSH, 0, rand64(),
                (k < 7) ? TAG_FUNC : (k < 9) ? TAG_HOST : 3'($urandom)));
            x.cmd = OP_CALL;
            send_op(x);
        end else if (r < 76) begin
            x.cmd = OP_RETURN;
            if ($urandom_range(0, 4) != 0) x.slot_or_count = 11'($urandom_range(0, sp));
            send_legal(x);
        end else if (r < 84) begin
            x.cmd = ($urandom_range(0, 1) != 0) ? OP_BRANCH : OP_CONDBRANCH;
            send_op(x);
        end else if (r < 89) begin
            x.cmd = ($urandom_range(0, 1) != 0) ? OP_LABEL : OP_NEW_FRAME;
            send_op(x);
        end else if (r < 92) begin
            x.cmd = 5'($urandom_range(int'(OP_LABEL) + 1, 31));
            send_op(x);
        end else begin
            send_legal(x);
        end
    endtask

    // Directed table: the expected result is typed in for the rows that can
    // be read off directly; the others go through the shadow machine.
    typedef struct {
        instr_t  ins;
        bit      fixed;
        result_t res;
    } stim_row_t;

    localparam logic [63:0] MAX_INT = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] MIN_INT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

    initial begin
        stim_row_t   rows[$];
        int          n;
        instr_t      x;
        rst_n = 1'b0;
        instr_valid = 1'b0;
        instr = '0;
        mismatches = 0;
        quiet = 1'b0;
        sp = 0;
        fp = 0;
        cdepth = 0;
        is_halted = 1'b0;
        foreach (slot_written[i]) slot_written[i] = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        rows.push_back('{make_instr(OP_LABEL, 0, 0, 0), 1, '{ST_OK, 0, 0, 0, 0, 0}});
        rows.push_back('{make_instr(OP_POPN, 1, 0, 0), 1, '{ST_STACK, 0, 0, 0, 0, 0}});
        rows.push_back('{make_instr(5'd31, 2047, ALL_ONES, 7), 1,
                         '{ST_UNKNOWN, 0, 0, 0, 0, 0}});
        rows.push_back('{make_instr(OP_PUSH, 0, MAX_INT, TAG_INT), 1,
                         '{ST_OK, 0, 0, MAX_INT, TAG_INT, 1}});
        rows.push_back('{make_instr(OP_PUSH, 0, MIN_INT, TAG_INT), 1,
                         '{ST_OK, 0, 0, MIN_INT, TAG_INT, 2}});
        // Largest plus smallest gives minus one.
        rows.push_back('{make_instr(OP_ADD, 0, 0, 0), 1,
                         '{ST_OK, 0, 0, ALL_ONES, TAG_INT, 1}});
        rows.push_back('{make_instr(OP_PUSH, 0, MIN_INT, TAG_INT), 0, '0});
        rows.push_back('{make_instr(OP_PUSH, 0, ALL_ONES, TAG_INT), 0, '0});
        // The most negative value divided by minus one stays put.
        rows.push_back('{make_instr(OP_DIV, 0, 0, 0), 1,
                         '{ST_OK, 0, 0, MIN_INT, TAG_INT, 2}});
        rows.push_back('{make_instr(OP_PUSH, 0, 0, TAG_INT), 0, '0});
        rows.push_back('{make_instr(OP_DIV, 0, 0, 0), 1,
                         '{ST_DIVZERO, 0, 0, 0, TAG_INT, 3}});
        rows.push_back('{make_instr(OP_PUSH, 0, 7, 4), 0, '0});
        rows.push_back('{make_instr(OP_ADD, 0, 0, 0), 1, '{ST_TYPE, 0, 0, 7, 4, 4}});
        rows.push_back('{make_instr(OP_POPN, 2, 0, 0), 0, '0});
        rows.push_back('{make_instr(OP_MUL, 0, 0, 0), 0, '0});
        rows.push_back('{make_instr(OP_LESS, 0, 0, 0), 0, '0});
        rows.push_back('{make_instr(OP_PUSH, 0, 5, TAG_INT), 0, '0});
        rows.push_back('{make_instr(OP_LESS, 0, 0, 0), 0, '0});
        rows.push_back('{make_instr(OP_POP_GLOBAL, 2047, 0, 0), 0, '0});
        rows.push_back('{make_instr(OP_PUSH_GLOBAL, 1024, 0, 0), 0, '0});
        rows.push_back('{make_instr(OP_POP_GLOBAL, 0, 0, 0), 0, '0});
        rows.push_back('{make_instr(OP_PUSH_GLOBAL, 0, 0, 0), 0, '0});
        rows.push_back('{make_instr(OP_PUSH, 0, 64'h0000_0000_dead_beef, TAG_HOST), 0, '0});
        rows.push_back('{make_instr(OP_CALL, 0, 0, 0), 0, '0});
        rows.push_back('{make_instr(OP_PUSH, 0, ALL_ONES, 3'd7), 0, '0});
        rows.push_back('{make_instr(OP_CALL, 0, 0, 0), 0, '0});
        foreach (rows[i]) send(rows[i].ins, rows[i].fixed, rows[i].res);

        n = 0;
        while (n < RANDOM_ITEMS) begin
            if (n == 100) begin
                // Fill the value stack to the brim, then try to overflow it with a push and a global push.
                while (sp < STACK_DEPTH)
                    send_op(make_instr(OP_PUSH, 0, rand64(), 3'($urandom)));
                send_op(make_instr(OP_PUSH, 0, rand64(), TAG_INT));
                send_op(make_instr(OP_PUSH_GLOBAL, 0, 0, 0));
                send_legal(make_instr(OP_RETURN, 0, 0, 0));
                send_op(make_instr(OP_POPN, sp - 2, 0, 0));
            end
            if (n == 150) begin
                // Let the block drain completely before going on.
                instr_valid <= 1'b0;
                while (pending_results.size() != 0) @(negedge clk);
            end
            if (n == 200) begin
                // Nest calls past the call stack limit, then unwind.
                send_op(make_instr(OP_PUSH, 0, rand64(), TAG_INT));
                repeat (CALL_DEPTH + 1) begin
                    send_op(make_instr(OP_PUSH, 0, rand64(), TAG_FUNC));
                    send_op(make_instr(OP_CALL, 0, 0, 0));
                end
                send_op(make_instr(OP_POPN, 1, 0, 0));
                repeat (CALL_DEPTH) send_op(make_instr(OP_RETURN, 1, 0, 0));
            end
            if (n >= RANDOM_ITEMS - 40) quiet = 1'b1;
            random_step();
            n++;
        end

        // Unwind every frame, then return from the outermost one to halt.
        while (cdepth > 0) begin
            if (sp == 0) send_op(make_instr(OP_PUSH, 0, rand64(), TAG_INT));
            send_op(make_instr(OP_RETURN, 1, 0, 0));
        end
        if (sp == 0) send_op(make_instr(OP_PUSH, 0, rand64(), TAG_INT));
        send_op(make_instr(OP_RETURN, 1, 0, 0));
        repeat (4) begin
            x = make_instr(5'($urandom), 0, rand64(), 3'($urandom));
            send_op(x);
        end
        instr_valid <= 1'b0;

        while (pending_results.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    // Receiver side: random stall bursts, none in the closing stretch.
    initial begin
        int burst;
        burst = 0;
        result_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (burst == 0 && !quiet && $urandom_range(0, 5) == 0)
                burst = $urandom_range(1, 11);
            result_stall <= (burst > 0);
            if (burst > 0) burst--;
        end
    end

    function automatic void report_field(string name, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= 10)
            $display("result mismatch at %0t: %s expected %h, got %h", $realtime, name, want,
                     got);
    endfunction

    // Checker: every accepted result against the oldest expectation.
    always @(posedge clk) begin
        result_t want;
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result at %0t with no item outstanding", $realtime);
            end else begin
                want = pending_results.pop_front();
                if (result.status !== want.status)
                    report_field("status", 64'(result.status), 64'(want.status));
                if (result.redirect !== want.redirect)
                    report_field("redirect", 64'(result.redirect), 64'(want.redirect));
                if (result.next_pc !== want.next_pc)
                    report_field("next_pc", 64'(result.next_pc), 64'(want.next_pc));
                if (result.top_value !== want.top_value)
                    report_field("top_value", result.top_value, want.top_value);
                if (result.top_tag !== want.top_tag)
                    report_field("top_tag", 64'(result.top_tag), 64'(want.top_tag));
                if (result.stack_depth !== want.stack_depth)
                    report_field("stack_depth", 64'(result.stack_depth),
                                 64'(want.stack_depth));
            end
        end
    end

    // Watchdog: ends the run when no handshake happens for too long.
    always @(posedge clk) begin
        if (!rst_n || (instr_valid === 1'b1 && instr_stall === 1'b0)
            || (result_valid === 1'b1 && result_stall === 1'b0)
            || pending_results.size() == 0)
            idle_cycles <= 0;
        else if (idle_cycles >= HANG_LIMIT) begin
            $display("tb_top NOT OK");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
